FILE: rtl/stokes_weight_apply_remove_unit_assert.svh
// Assertion macros for the Stokes weight apply / remove unit.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef STOKES_WEIGHT_APPLY_REMOVE_UNIT_ASSERT_SVH
`define STOKES_WEIGHT_APPLY_REMOVE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define SWAR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SWAR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWAR_ASSERT_NOW(lbl, ante, cons, msg)
`define SWAR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/swar_pkg.sv
// Shared types and constants for the Stokes weight apply / remove unit.
// No dependencies.
`timescale 1ns / 1ps
package swar_pkg;

   // Default number of fraction bits of the fixed point format.
   localparam int FRAC_BITS_DEF = 16;

   // Result width and the depth of the pipelined divider.
   localparam int RES_W  = 32;
   localparam int DIV_ST = RES_W + 2;

   // Width of exact products of a weight and a cofactor, and of their sums.
   localparam int PRW = 97;
   localparam int DW  = 98;

   // Configuration port.
   localparam int CSR_IDX_W = 4;
   localparam int THR_W     = 33;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARIZED = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DET_THR   = 4'd1;

   // Opcodes.
   localparam logic OP_APPLY  = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic signed [31:0] sig_t;
      logic signed [31:0] sig_q;
      logic signed [31:0] sig_u;
      logic signed [31:0] w_tt;
      logic signed [31:0] w_tq;
      logic signed [31:0] w_tu;
      logic signed [31:0] w_qq;
      logic signed [31:0] w_qu;
      logic signed [31:0] w_uu;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_t;
      logic signed [31:0] res_q;
      logic signed [31:0] res_u;
      logic              singular;
      logic              saturated;
   } rsp_type;

endpackage

FILE: rtl/swar_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, rounded quotient.
// Depends on swar_pkg.
`timescale 1ns / 1ps
module swar_div_pipe import swar_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic [DIV_ST-1:0] adv,
   input  logic [DW-1:0]     in_mn,
   input  logic [DW-1:0]     in_md,
   input  logic              in_neg,
   output logic [RES_W-1:0]  out_q,
   output logic              out_ovf,
   output logic              out_neg
);

   localparam int RW = DW + FRAC_BITS + 34;

   logic [RW-1:0]    rem_ff [DIV_ST];
   logic [DW:0]      den_ff [DIV_ST];
   logic [RES_W-1:0] quo_ff [DIV_ST];
   logic             ovf_ff [DIV_ST];
   logic             neg_ff [DIV_ST];

   // Build the rounding dividend 2*n*2^F + d and the divisor 2*d.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= (RW'(in_mn) << (FRAC_BITS + 1)) + RW'(in_md);
         den_ff[0] <= {in_md, 1'b0};
         quo_ff[0] <= '0;
         ovf_ff[0] <= 1'b0;
         neg_ff[0] <= in_neg;
      end
   end

   // A quotient that needs more than the result width saturates anyway.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         rem_ff[1] <= rem_ff[0];
         den_ff[1] <= den_ff[0];
         quo_ff[1] <= quo_ff[0];
         ovf_ff[1] <= rem_ff[0] >= (RW'(den_ff[0]) << RES_W);
         neg_ff[1] <= neg_ff[0];
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar j = 2; j < DIV_ST; j++) begin : g_bit
      localparam int B = DIV_ST - 1 - j;
      logic [RW-1:0]    dsh;
      logic             ge;
      logic [RES_W-1:0] quo_in;

      assign dsh = RW'(den_ff[j-1]) << B;
      assign ge  = rem_ff[j-1] >= dsh;

      always_comb begin
         quo_in    = quo_ff[j-1];
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j] <= ge ? rem_ff[j-1] - dsh : rem_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= quo_in;
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign out_q   = quo_ff[DIV_ST-1];
   assign out_ovf = ovf_ff[DIV_ST-1];
   assign out_neg = neg_ff[DIV_ST-1];

endmodule

FILE: rtl/stokes_weight_apply_remove_unit.sv
// Stokes weight apply / remove unit: top level pipeline and register file.
// Depends on swar_pkg, swar_div_pipe and stokes_weight_apply_remove_unit_assert.svh.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (rsp_type)
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One item per cycle sustained while rsp_ready stays high.
// The divider resolves one quotient bit per stage.
// Reset clears all stage valid bits and loads polarized = 1, det_threshold = 1.
// Each full stage holds only while the next one holds, so a stall at rsp drains bubbles
// first and inputs are still taken while any stage is empty.
`timescale 1ns / 1ps
`include "stokes_weight_apply_remove_unit_assert.svh"
module stokes_weight_apply_remove_unit import swar_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata
);

   localparam int ST_DIV0 = 7;
   localparam int NST     = ST_DIV0 + DIV_ST + 1;
   localparam int DOT_W   = 66;
   localparam int SAT_W   = 67;

   typedef struct packed {
      logic [RES_W-1:0] val;
      logic             sat;
   } rnd_type;

   typedef struct packed {
      logic [RES_W-1:0] res_t;
      logic [RES_W-1:0] res_q;
      logic [RES_W-1:0] res_u;
      logic             sing;
      logic             sat;
      logic             div_t;
      logic             div_qu;
   } sb_type;

   // Clamp a magnitude to the signed result range and apply the sign.
   function automatic rnd_type sat_out(input logic neg, input logic [SAT_W-1:0] m);
      logic [SAT_W-1:0] lim;
      rnd_type          r;
      lim   = neg ? (SAT_W'(1) << (RES_W - 1))
                  : ((SAT_W'(1) << (RES_W - 1)) - SAT_W'(1));
      r.sat = m > lim;
      r.val = r.sat ? lim[RES_W-1:0] : m[RES_W-1:0];
      if (neg) begin
         r.val = -r.val;
      end
      return r;
   endfunction

   // Drop the fraction bits, rounding to nearest with ties away from zero.
   function automatic rnd_type round_shift(input logic signed [DOT_W-1:0] x);
      logic signed [SAT_W-1:0] xs;
      logic [SAT_W-1:0]        m;
      xs = SAT_W'(x);
      m  = x[DOT_W-1] ? unsigned'(-xs) : unsigned'(xs);
      m  = m + (SAT_W'(1) << (FRAC_BITS - 1));
      m  = m >> FRAC_BITS;
      return sat_out(x[DOT_W-1], m);
   endfunction

   // Register file.
   logic             polarized_ff;
   logic [THR_W-1:0] thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarized_ff <= 1'b1;
         thr_ff       <= THR_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POLARIZED: polarized_ff <= csr_wdata[0];
            CSR_DET_THR:   thr_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage valid bits and the per-stage advance chain.
   logic [NST-1:0] v_ff;
   logic [NST-1:0] adv;

   assign adv[NST-1] = !v_ff[NST-1] || rsp_ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Input item copies for the stages that still need it.
   req_type x_ff [6];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0] <= req_data;
      end
      for (int k = 1; k < 6; k++) begin
         if (adv[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
   end

   // Stage 1: products for the apply path and for the cofactors.
   logic signed [63:0] pa_in [9];
   logic signed [63:0] pc_in [12];
   logic signed [63:0] pa_ff [9];
   logic signed [63:0] pc_ff [12];

   always_comb begin
      pa_in[0]  = x_ff[0].w_tt * x_ff[0].sig_t;
      pa_in[1]  = x_ff[0].w_tq * x_ff[0].sig_q;
      pa_in[2]  = x_ff[0].w_tu * x_ff[0].sig_u;
      pa_in[3]  = x_ff[0].w_tq * x_ff[0].sig_t;
      pa_in[4]  = x_ff[0].w_qq * x_ff[0].sig_q;
      pa_in[5]  = x_ff[0].w_qu * x_ff[0].sig_u;
      pa_in[6]  = x_ff[0].w_tu * x_ff[0].sig_t;
      pa_in[7]  = x_ff[0].w_qu * x_ff[0].sig_q;
      pa_in[8]  = x_ff[0].w_uu * x_ff[0].sig_u;
      pc_in[0]  = x_ff[0].w_qq * x_ff[0].w_uu;
      pc_in[1]  = x_ff[0].w_qu * x_ff[0].w_qu;
      pc_in[2]  = x_ff[0].w_tq * x_ff[0].w_uu;
      pc_in[3]  = x_ff[0].w_tu * x_ff[0].w_qu;
      pc_in[4]  = x_ff[0].w_tq * x_ff[0].w_qu;
      pc_in[5]  = x_ff[0].w_tu * x_ff[0].w_qq;
      pc_in[6]  = x_ff[0].w_tt * x_ff[0].w_uu;
      pc_in[7]  = x_ff[0].w_tu * x_ff[0].w_tu;
      pc_in[8]  = x_ff[0].w_tt * x_ff[0].w_qu;
      pc_in[9]  = x_ff[0].w_tq * x_ff[0].w_tu;
      pc_in[10] = x_ff[0].w_tt * x_ff[0].w_qq;
      pc_in[11] = x_ff[0].w_tq * x_ff[0].w_tq;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pa_ff <= pa_in;
         pc_ff <= pc_in;
      end
   end

   // Stage 2: cofactors (tt, tq, tu, qq, qu, uu) and the apply dot products.
   // Unpolarized apply uses only tt * t on the t lane.
   logic signed [63:0]      cof_in [6];
   logic signed [DOT_W-1:0] dot_in [3];
   logic signed [63:0]      cof_ff [6];
   logic signed [DOT_W-1:0] dot_ff [3];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         cof_in[i] = pc_ff[2*i] - pc_ff[2*i+1];
      end
      for (int i = 0; i < 3; i++) begin
         dot_in[i] = DOT_W'(pa_ff[3*i]) + DOT_W'(pa_ff[3*i+1]) + DOT_W'(pa_ff[3*i+2]);
      end
      if (!polarized_ff) begin
         dot_in[0] = DOT_W'(pa_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cof_ff <= cof_in;
         dot_ff <= dot_in;
      end
   end

   // Stage 3: weight by cofactor products cut into 32 bit halves, and the
   // rounded apply results or pass-through values.
   logic signed [31:0] ma [12];
   logic signed [63:0] mc [12];
   logic signed [64:0] pl_in [12];
   logic signed [63:0] ph_in [12];
   logic signed [64:0] pl_ff [12];
   logic signed [63:0] ph_ff [12];
   rnd_type            rt3, rq3, ru3;
   logic               active3, apl3;
   sb_type             sb3_in;
   sb_type             sb_ff [3:NST-2];

   always_comb begin
      ma[0]  = x_ff[2].w_tt;  mc[0]  = cof_ff[0];
      ma[1]  = x_ff[2].w_tq;  mc[1]  = cof_ff[1];
      ma[2]  = x_ff[2].w_tu;  mc[2]  = cof_ff[2];
      ma[3]  = x_ff[2].sig_t; mc[3]  = cof_ff[0];
      ma[4]  = x_ff[2].sig_q; mc[4]  = cof_ff[1];
      ma[5]  = x_ff[2].sig_u; mc[5]  = cof_ff[2];
      ma[6]  = x_ff[2].sig_t; mc[6]  = cof_ff[1];
      ma[7]  = x_ff[2].sig_q; mc[7]  = cof_ff[3];
      ma[8]  = x_ff[2].sig_u; mc[8]  = cof_ff[4];
      ma[9]  = x_ff[2].sig_t; mc[9]  = cof_ff[2];
      ma[10] = x_ff[2].sig_q; mc[10] = cof_ff[4];
      ma[11] = x_ff[2].sig_u; mc[11] = cof_ff[5];
      for (int k = 0; k < 12; k++) begin
         pl_in[k] = ma[k] * $signed({1'b0, mc[k][31:0]});
         ph_in[k] = ma[k] * $signed(mc[k][63:32]);
      end
   end

   always_comb begin
      rt3     = round_shift(dot_ff[0]);
      rq3     = round_shift(dot_ff[1]);
      ru3     = round_shift(dot_ff[2]);
      active3 = polarized_ff
              ? (x_ff[2].sig_t != 0 || x_ff[2].sig_q != 0 || x_ff[2].sig_u != 0)
              : (x_ff[2].sig_t != 0);
      apl3    = active3 && (x_ff[2].opcode == OP_APPLY);
      sb3_in.res_t  = apl3 ? rt3.val : x_ff[2].sig_t;
      sb3_in.res_q  = (apl3 && polarized_ff) ? rq3.val : x_ff[2].sig_q;
      sb3_in.res_u  = (apl3 && polarized_ff) ? ru3.val : x_ff[2].sig_u;
      sb3_in.sat    = apl3 && (rt3.sat || (polarized_ff && (rq3.sat || ru3.sat)));
      sb3_in.sing   = 1'b0;
      sb3_in.div_t  = 1'b0;
      sb3_in.div_qu = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
      end
   end

   // Stage 4: join the halves into full products.
   logic signed [PRW-1:0] prod_in [12];
   logic signed [PRW-1:0] prod_ff [12];

   always_comb begin
      for (int k = 0; k < 12; k++) begin
         prod_in[k] = PRW'($signed({ph_ff[k], 32'b0})) + PRW'(pl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 5: determinant and the three numerators. Unpolarized remove
   // divides t by tt on the t lane.
   logic signed [DW-1:0] det_in, dent_in;
   logic signed [DW-1:0] num_in [3];
   logic signed [DW-1:0] det_ff, dent_ff;
   logic signed [DW-1:0] num_ff [3];

   always_comb begin
      det_in    = DW'(prod_ff[0]) - DW'(prod_ff[1]) + DW'(prod_ff[2]);
      num_in[0] = DW'(prod_ff[3]) - DW'(prod_ff[4]) + DW'(prod_ff[5]);
      num_in[1] = DW'(prod_ff[7]) - DW'(prod_ff[6]) - DW'(prod_ff[8]);
      num_in[2] = DW'(prod_ff[9]) - DW'(prod_ff[10]) + DW'(prod_ff[11]);
      dent_in   = det_in;
      if (!polarized_ff) begin
         num_in[0] = DW'(x_ff[4].sig_t);
         dent_in   = DW'(x_ff[4].w_tt);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         det_ff  <= det_in;
         dent_ff <= dent_in;
         num_ff  <= num_in;
      end
   end

   // Stage 6: singular test, magnitudes and signs for the divider lanes.
   logic [DW-1:0] mn_in [3];
   logic [DW-1:0] md_in [3];
   logic          neg_in [3];
   logic [DW-1:0] mn_ff [3];
   logic [DW-1:0] md_ff [3];
   logic          neg_ff [3];
   logic [DW-1:0] thr_w;
   logic          det_ok, active6, remove6, sing6;
   sb_type        sb6_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mn_in[i] = num_ff[i][DW-1] ? unsigned'(-num_ff[i]) : unsigned'(num_ff[i]);
      end
      md_in[0]  = dent_ff[DW-1] ? unsigned'(-dent_ff) : unsigned'(dent_ff);
      md_in[1]  = det_ff[DW-1] ? unsigned'(-det_ff) : unsigned'(det_ff);
      md_in[2]  = md_in[1];
      neg_in[0] = num_ff[0][DW-1] ^ dent_ff[DW-1];
      neg_in[1] = num_ff[1][DW-1] ^ det_ff[DW-1];
      neg_in[2] = num_ff[2][DW-1] ^ det_ff[DW-1];

      thr_w   = DW'(thr_ff) << FRAC_BITS;
      det_ok  = !det_ff[DW-1] && (det_ff != 0) && (unsigned'(det_ff) >= thr_w);
      active6 = polarized_ff
              ? (x_ff[5].sig_t != 0 || x_ff[5].sig_q != 0 || x_ff[5].sig_u != 0)
              : (x_ff[5].sig_t != 0);
      remove6 = active6 && (x_ff[5].opcode == OP_REMOVE);
      sing6   = remove6 && ((x_ff[5].w_tt == 0) || (polarized_ff && !det_ok));

      sb6_in = sb_ff[5];
      if (sing6) begin
         sb6_in.res_t = '0;
         sb6_in.res_q = '0;
         sb6_in.res_u = '0;
         sb6_in.sat   = 1'b0;
         sb6_in.sing  = 1'b1;
      end else if (remove6) begin
         sb6_in.div_t  = 1'b1;
         sb6_in.div_qu = polarized_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         mn_ff    <= mn_in;
         md_ff    <= md_in;
         neg_ff   <= neg_in;
      end
   end

   // Sideband travels beside the data from stage 3 on; stage 6 adds the
   // singular test and the divider lane selects.
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         sb_ff[3] <= sb3_in;
      end
      for (int k = 4; k < NST - 1; k++) begin
         if (adv[k]) begin
            sb_ff[k] <= (k == 6) ? sb6_in : sb_ff[k-1];
         end
      end
   end

   // Divider lanes for t, q and u.
   logic [RES_W-1:0] dq   [3];
   logic             dovf [3];
   logic             dneg [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      swar_div_pipe #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .adv     (adv[ST_DIV0 +: DIV_ST]),
         .in_mn   (mn_ff[i]),
         .in_md   (md_ff[i]),
         .in_neg  (neg_ff[i]),
         .out_q   (dq[i]),
         .out_ovf (dovf[i]),
         .out_neg (dneg[i])
      );
   end

   // Output stage: pick divider results where the item was a remove.
   rnd_type dr [3];
   sb_type  sbo;
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dr[i] = sat_out(dneg[i], {{(SAT_W - RES_W - 1){1'b0}}, dovf[i], dq[i]});
      end
      sbo              = sb_ff[NST-2];
      rsp_in.res_t     = sbo.div_t  ? dr[0].val : sbo.res_t;
      rsp_in.res_q     = sbo.div_qu ? dr[1].val : sbo.res_q;
      rsp_in.res_u     = sbo.div_qu ? dr[2].val : sbo.res_u;
      rsp_in.singular  = sbo.sing;
      rsp_in.saturated = sbo.sat || (sbo.div_t && dr[0].sat)
                       || (sbo.div_qu && (dr[1].sat || dr[2].sat));
   end

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[NST-1];
   assign rsp_data  = rsp_ff;

   // Checks on the pipeline control, the divider lane selects and singular results.
   logic sing_clean;

   assign sing_clean = rsp_data.res_t == 0 && rsp_data.res_q == 0
                     && rsp_data.res_u == 0 && !rsp_data.saturated;

   `SWAR_ASSERT_NEXT(a_accept_lands, req_valid && req_ready, v_ff[0], "accepted item lost")
   `SWAR_ASSERT_NOW(a_qu_div_pol, v_ff[6] && sb_ff[6].div_qu, polarized_ff, "q/u divide unpolarized")
   `SWAR_ASSERT_NOW(a_sing_clean, rsp_valid && rsp_data.singular, sing_clean, "singular not cleared")

endmodule

FILE: sim/tb_stokes_weight_apply_remove_unit.sv
// Testbench for the Stokes weight apply / remove unit.
// Depends on swar_pkg and stokes_weight_apply_remove_unit; predicts results with wide math.
`timescale 1ns / 1ps
module tb_stokes_weight_apply_remove_unit import swar_pkg::*; ;

   typedef logic signed [199:0] wide_type;
   typedef logic [199:0]        wideu_type;

   localparam int FB = FRAC_BITS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd9;
   localparam int NUM_PHASES = 6;
   localparam int RAND_PER_PHASE = 325;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0] csr_wdata = '0;

   // Testbench copy of the configuration registers.
   bit               cfg_polarized = 1'b1;
   logic [THR_W-1:0] cfg_threshold = 33'd1;

   req_type pixel_q[$];
   rsp_type expected_q[$];
   int      errors = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   bit      hold_send = 1'b0;
   bit      no_idle = 1'b0;

   stokes_weight_apply_remove_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Clamp a magnitude to the signed 32 bit range and apply the sign.
   function automatic logic [31:0] clamp32(bit neg, wideu_type m, inout bit sat);
      wideu_type lim;
      lim = neg ? wideu_type'(32'h8000_0000) : wideu_type'(32'h7fff_ffff);
      if (m > lim) begin
         sat = 1'b1;
         m = lim;
      end
      return neg ? (32'd0 - m[31:0]) : m[31:0];
   endfunction

   // Round to nearest, ties away from zero, dropping the fraction bits.
   function automatic logic [31:0] round_frac(wide_type x, inout bit sat);
      bit        neg;
      wideu_type m;
      neg = (x < 0);
      m = neg ? wideu_type'(-x) : wideu_type'(x);
      m = (m + (wideu_type'(1) << (FB - 1))) >> FB;
      return clamp32(neg, m, sat);
   endfunction

   // Rounded fixed point quotient num / den.
   function automatic logic [31:0] round_quot(wide_type num, wide_type den, inout bit sat);
      bit        nn, nd;
      wideu_type mn, md, q;
      nn = (num < 0);
      nd = (den < 0);
      mn = nn ? wideu_type'(-num) : wideu_type'(num);
      md = nd ? wideu_type'(-den) : wideu_type'(den);
      q = ((mn << (FB + 1)) + md) / (md << 1);
      return clamp32(nn != nd, q, sat);
   endfunction

   // Expected result of one pixel under the current configuration.
   function automatic rsp_type weigh_pixel(req_type r);
      rsp_type  o;
      bit       sing, sat;
      wide_type t, q, u, tt, tq, tu, qq, qu, uu;
      wide_type att, atq, atu, aqq, aqu, auu, det, thr;
      t = r.sig_t; q = r.sig_q; u = r.sig_u;
      tt = r.w_tt; tq = r.w_tq; tu = r.w_tu;
      qq = r.w_qq; qu = r.w_qu; uu = r.w_uu;
      sing = 1'b0;
      sat = 1'b0;
      o.res_t = r.sig_t;
      o.res_q = r.sig_q;
      o.res_u = r.sig_u;
      if (cfg_polarized) begin
         if (!(t == 0 && q == 0 && u == 0)) begin
            if (r.opcode == OP_APPLY) begin
               o.res_t = round_frac(tt * t + tq * q + tu * u, sat);
               o.res_q = round_frac(tq * t + qq * q + qu * u, sat);
               o.res_u = round_frac(tu * t + qu * q + uu * u, sat);
            end else begin
               att = qq * uu - qu * qu;
               atq = tq * uu - tu * qu;
               atu = tq * qu - tu * qq;
               aqq = tt * uu - tu * tu;
               aqu = tt * qu - tq * tu;
               auu = tt * qq - tq * tq;
               det = tt * att - tq * atq + tu * atu;
               thr = wide_type'({1'b0, cfg_threshold}) <<< FB;
               if (tt == 0 || det <= 0 || det < thr) begin
                  sing = 1'b1;
               end else begin
                  o.res_t = round_quot(t * att - q * atq + u * atu, det, sat);
                  o.res_q = round_quot(-t * atq + q * aqq - u * aqu, det, sat);
                  o.res_u = round_quot(t * atu - q * aqu + u * auu, det, sat);
               end
            end
         end
      end else if (t != 0) begin
         if (r.opcode == OP_APPLY) begin
            o.res_t = round_frac(tt * t, sat);
         end else if (tt == 0) begin
            sing = 1'b1;
         end else begin
            o.res_t = round_quot(t, tt, sat);
         end
      end
      if (sing) begin
         o.res_t = '0;
         o.res_q = '0;
         o.res_u = '0;
         sat = 1'b0;
      end
      o.singular = sing;
      o.saturated = sat;
      return o;
   endfunction

   function automatic req_type mk_pixel(logic op, logic [31:0] t, logic [31:0] q,
                                        logic [31:0] u, logic [31:0] tt, logic [31:0] tq,
                                        logic [31:0] tu, logic [31:0] qq, logic [31:0] qu,
                                        logic [31:0] uu);
      req_type r;
      r.opcode = op;
      r.sig_t = t; r.sig_q = q; r.sig_u = u;
      r.w_tt = tt; r.w_tq = tq; r.w_tu = tu;
      r.w_qq = qq; r.w_qu = qu; r.w_uu = uu;
      return r;
   endfunction

   // Append one pixel to the pending queue.
   task automatic add_pixel(req_type r);
      pixel_q = {pixel_q, r};
   endtask

   // A field value with extremes weighted in.
   function automatic logic [31:0] any_value();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0001_0000;
         5: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Random pixel: mostly a well conditioned matrix, the rest noise.
   function automatic req_type rand_pixel();
      req_type r;
      int      k;
      k = $urandom_range(0, 99);
      r.opcode = 1'($urandom_range(0, 1));
      if (k < 60) begin
         r.w_tt = $urandom_range(32'h0000_1000, 32'h0080_0000);
         r.w_qq = $urandom_range(32'h0000_1000, 32'h0080_0000);
         r.w_uu = $urandom_range(32'h0000_1000, 32'h0080_0000);
         r.w_tq = $signed($urandom_range(0, 32'h800)) - 32'sh400;
         r.w_tu = $signed($urandom_range(0, 32'h800)) - 32'sh400;
         r.w_qu = $signed($urandom_range(0, 32'h800)) - 32'sh400;
         r.sig_t = ($urandom_range(0, 7) == 0) ? any_value() : $urandom;
         r.sig_q = ($urandom_range(0, 7) == 0) ? any_value() : $urandom;
         r.sig_u = ($urandom_range(0, 7) == 0) ? any_value() : $urandom;
      end else begin
         r.sig_t = any_value(); r.sig_q = any_value(); r.sig_u = any_value();
         r.w_tt = any_value(); r.w_tq = any_value(); r.w_tu = any_value();
         r.w_qq = any_value(); r.w_qu = any_value(); r.w_uu = any_value();
      end
      if (k >= 95) begin
         r.sig_t = '0;
         if (k >= 97) begin
            r.sig_q = '0;
            r.sig_u = '0;
         end
      end
      return r;
   endfunction

   // Input driver: takes pixels from the pending queue with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_q = {expected_q, weigh_pixel(req_data)};
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0 && !hold_send) begin
               req_data <= pixel_q.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: random back pressure and field by field checks.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors = errors + 1;
               $display("%0t: result with no item pending: %p", $realtime, rsp_data);
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.res_t !== e.res_t) begin
                  errors = errors + 1;
                  $display("%0t: res_t expected %h actual %h", $realtime, e.res_t,
                           rsp_data.res_t);
               end
               if (rsp_data.res_q !== e.res_q) begin
                  errors = errors + 1;
                  $display("%0t: res_q expected %h actual %h", $realtime, e.res_q,
                           rsp_data.res_q);
               end
               if (rsp_data.res_u !== e.res_u) begin
                  errors = errors + 1;
                  $display("%0t: res_u expected %h actual %h", $realtime, e.res_u,
                           rsp_data.res_u);
               end
               if (rsp_data.singular !== e.singular) begin
                  errors = errors + 1;
                  $display("%0t: singular expected %b actual %b", $realtime, e.singular,
                           rsp_data.singular);
               end
               if (rsp_data.saturated !== e.saturated) begin
                  errors = errors + 1;
                  $display("%0t: saturated expected %b actual %b", $realtime, e.saturated,
                           rsp_data.saturated);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   // Register write; only called while the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_POLARIZED) cfg_polarized = val[0];
      else if (idx == CSR_DET_THR) cfg_threshold = val;
   endtask

   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Stimulus sequence over several register settings.
   initial begin
      bit               pol;
      logic [THR_W-1:0] thr;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin pol = 1'b1; thr = 33'd1; end
            1: begin pol = 1'b0; thr = 33'd1; end
            2: begin pol = 1'b1; thr = 33'd0; end
            3: begin pol = 1'b1; thr = 33'h1_0000_0000; end
            4: begin pol = 1'b0; thr = {1'($urandom_range(0, 1)), $urandom}; end
            default: begin pol = 1'b1; thr = THR_W'($urandom_range(0, 32'h0010_0000)); end
         endcase
         write_reg(CSR_POLARIZED, THR_W'(pol));
         write_reg(CSR_DET_THR, thr);
         if (p == 0) write_reg(CSR_UNUSED, 33'h1_ffff_ffff);
         no_idle = (p == 3);
         if (p == 0 || p == 1) begin
            // Extremes, zero vector and zero t, singular and overflow cases.
            add_pixel(mk_pixel(OP_APPLY, 32'h10000, 32'h20000, 32'h30000,
               32'h10000, 0, 0, 32'h10000, 0, 32'h10000));
            add_pixel(mk_pixel(OP_REMOVE, 32'h10000, 32'h20000, 32'h30000,
               32'h20000, 32'h100, 32'h200, 32'h30000, 32'h80, 32'h40000));
            add_pixel(mk_pixel(OP_APPLY, 0, 0, 0, 32'h7fffffff, 1, 2, 3, 4, 5));
            add_pixel(mk_pixel(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            add_pixel(mk_pixel(OP_REMOVE, 0, 32'h10000, 32'hffff0000,
               32'h10000, 0, 0, 32'h10000, 0, 32'h10000));
            add_pixel(mk_pixel(OP_REMOVE, 32'h10000, 1, 1,
               0, 0, 0, 32'h10000, 0, 32'h10000));
            add_pixel(mk_pixel(OP_REMOVE, 32'h10000, 1, 1, 32'h10000,
               32'h10000, 0, 32'h10000, 0, 32'h10000));
            add_pixel(mk_pixel(OP_REMOVE, 32'h10000, 1, 1, 32'h1, 0, 0, 1, 0, 1));
            add_pixel(mk_pixel(OP_APPLY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff));
            add_pixel(mk_pixel(OP_APPLY, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000));
            add_pixel(mk_pixel(OP_APPLY, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h7fffffff));
            add_pixel(mk_pixel(OP_REMOVE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h100, 0, 0, 32'h100, 0, 32'h100));
            add_pixel(mk_pixel(OP_REMOVE, 32'h80000000, 0, 0, 32'hffffffff,
               0, 0, 32'hffffffff, 0, 32'hffffffff));
            add_pixel(mk_pixel(OP_APPLY, 32'h8000, 32'h8000, 32'h8000,
               1, 1, 1, 1, 1, 1));
            add_pixel(mk_pixel(OP_APPLY, 32'hffff8000, 0, 0, 1, 0, 0, 0, 0, 0));
            add_pixel(mk_pixel(OP_REMOVE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff));
         end
         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            add_pixel(rand_pixel());
            if (p == 2 && i == RAND_PER_PHASE / 2) begin
               // Sender holds off until every pending result is back.
               while (pixel_q.size() > 0 || req_valid) @(posedge clock);
               hold_send = 1'b1;
               while (expected_q.size() > 0) @(posedge clock);
               hold_send = 1'b0;
            end
         end
         wait_drained();
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run time limit.
   initial begin
      #(64'd60_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
